// ===== design/bcz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier easing package
// Fixed-point widths, reset values, register indexes and the stage bundle
// shared by the bisection pipeline.
// ----------------------------------------------------------------------------
package bcz_pkg;

	localparam int FRAC_BITS = 16;
	localparam int QW        = FRAC_BITS + 1;    // 0..ONE
	localparam int BW        = FRAC_BITS + 2;    // Bernstein terms b1, b2
	localparam int XW        = FRAC_BITS + 5;    // x sum
	localparam int PROG_W    = 18;
	localparam int CY_W      = 18;
	localparam int DATA_W    = 18;
	localparam int EASED_W   = 19;
	localparam int PSW       = BW + CY_W + 1 - FRAC_BITS;
	localparam int SUM_W     = PSW + 2;

	localparam int BISECT_STEPS_DEF = 10;

	localparam logic [QW-1:0] ONE       = QW'(1) << FRAC_BITS;
	localparam logic [QW-1:0] CTRL1_X_RST = QW'((42 * (1 << FRAC_BITS) + 50) / 100);
	localparam logic [QW-1:0] CTRL2_X_RST = QW'((58 * (1 << FRAC_BITS) + 50) / 100);
	localparam logic signed [CY_W-1:0] CTRL1_Y_RST = '0;
	localparam logic signed [CY_W-1:0] CTRL2_Y_RST = CY_W'(1 << FRAC_BITS);

	localparam logic signed [SUM_W-1:0] EASED_MIN = -SUM_W'(131072);
	localparam logic signed [SUM_W-1:0] EASED_MAX = SUM_W'(131072);

	typedef enum logic [1:0] {
		CFG_CTRL1_X,
		CFG_CTRL1_Y,
		CFG_CTRL2_X,
		CFG_CTRL2_Y
	} cfg_reg_t;

	typedef struct packed {
		logic [QW-1:0] t;
		logic [QW-1:0] low;
		logic [QW-1:0] high;
		logic [BW-1:0] b1;
		logic [BW-1:0] b2;
		logic [QW-1:0] b3;
	} bcz_step_t;

endpackage
`default_nettype wire

// ===== design/cubic_bezier_easing_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier easing
// Clamps progress, bisects the curve parameter against x, evaluates y at the
// final mid point and returns the saturated eased value.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  progress  progress_valid / _stall   progress  (s18, Q2.16)
//  eased     eased_valid / _stall      eased     (s19, Q3.16)
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  One progress transfer per cycle while progress_stall is low; the stages are
//  the entry register, three stages per bisection step, two y stages, output.
//  The bisection chain sets the latency, one multiplier level per stage.
//  A skid register behind the output lets the pipeline finish one more
//  transfer under a stall; progress_stall rises while the skid is full.
//  Reset clears valid bits and loads the default control points.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_top #(
	parameter int BISECT_STEPS = bcz_pkg::BISECT_STEPS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 progress_valid,
	output logic                                      progress_stall,
	input  wire logic signed [bcz_pkg::PROG_W-1:0]    progress,
	output logic                                      eased_valid,
	input  wire logic                                 eased_stall,
	output logic signed [bcz_pkg::EASED_W-1:0]        eased,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire bcz_pkg::cfg_reg_t                    cfg_index,
	input  wire logic [bcz_pkg::DATA_W-1:0]           cfg_data
);
	import bcz_pkg::*;

	logic [QW-1:0]          px1_q, px2_q;
	logic signed [CY_W-1:0] py1_q, py2_q;
	logic [QW-1:0]          cfg_x;

	logic      en;
	logic      step_valid [0:BISECT_STEPS];
	bcz_step_t step_data  [0:BISECT_STEPS];
	logic [QW-1:0] t_clamp;

	logic               y_valid;
	logic [EASED_W-1:0] y_eased;
	logic               skid_valid_q;
	logic [EASED_W-1:0] skid_q, eased_q;
	logic               out_take;

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_x     = (cfg_data[QW-1:0] > ONE) ? ONE : cfg_data[QW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px1_q <= CTRL1_X_RST;
			py1_q <= CTRL1_Y_RST;
			px2_q <= CTRL2_X_RST;
			py2_q <= CTRL2_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CTRL1_X: px1_q <= cfg_x;
				CFG_CTRL1_Y: py1_q <= $signed(cfg_data[CY_W-1:0]);
				CFG_CTRL2_X: px2_q <= cfg_x;
				CFG_CTRL2_Y: py2_q <= $signed(cfg_data[CY_W-1:0]);
				default: ;
			endcase
		end
	end

	// entry: clamp progress
	assign en             = !skid_valid_q;
	assign progress_stall = skid_valid_q;

	always_comb begin
		if (progress < 0) begin
			t_clamp = '0;
		end else if (progress > $signed(PROG_W'(ONE))) begin
			t_clamp = ONE;
		end else begin
			t_clamp = progress[QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_valid[0] <= 1'b0;
		end else if (en) begin
			step_valid[0] <= progress_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_data[0].t    <= t_clamp;
			step_data[0].low  <= '0;
			step_data[0].high <= ONE;
			step_data[0].b1   <= '0;
			step_data[0].b2   <= '0;
			step_data[0].b3   <= '0;
		end
	end

	for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_step
		bcz_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (step_valid[i]),
			.in_data   (step_data[i]),
			.px1       (px1_q),
			.px2       (px2_q),
			.out_valid (step_valid[i+1]),
			.out_data  (step_data[i+1])
		);
	end

	bcz_yeval u_yeval (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (step_valid[BISECT_STEPS]),
		.in_data   (step_data[BISECT_STEPS]),
		.ctrl1_y   (py1_q),
		.ctrl2_y   (py2_q),
		.out_valid (y_valid),
		.out_eased (y_eased)
	);

	// output register with skid
	assign out_take = !eased_valid || !eased_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eased_valid  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				eased_valid  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_take) begin
			eased_valid <= y_valid;
		end else if (y_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				eased_q <= skid_q;
			end
		end else if (out_take) begin
			eased_q <= y_eased;
		end else begin
			skid_q <= y_eased;
		end
	end

	assign eased = $signed(eased_q);

endmodule
`default_nettype wire

// ===== design/bcz_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bisection step
// Three-stage step: mid and squares, Bernstein terms, x compare and
// interval update.
// ----------------------------------------------------------------------------
module bcz_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire bcz_pkg::bcz_step_t in_data,
	input  wire logic [bcz_pkg::QW-1:0] px1,
	input  wire logic [bcz_pkg::QW-1:0] px2,
	output logic                    out_valid,
	output bcz_pkg::bcz_step_t      out_data
);
	import bcz_pkg::*;

	logic [QW:0]     mid_sum;
	logic [QW-1:0]   mid_c, u_c;
	logic [2*QW-1:0] uu_prod, mm_prod;

	logic            valid_s1;
	logic [QW-1:0]   t_s1, low_s1, high_s1, mid_s1, u_s1, uu_s1, mm_s1;

	logic [QW+1:0]   tri_uu, tri_u;
	logic [2*QW+1:0] b1_prod, b2_prod;
	logic [2*QW-1:0] b3_prod;

	logic            valid_s2;
	logic [QW-1:0]   t_s2, low_s2, high_s2, mid_s2, b3_s2;
	logic [BW-1:0]   b1_s2, b2_s2;

	logic [BW+QW-1:0] x1_prod, x2_prod;
	logic [XW-1:0]    x_c;
	logic             below;

	// mid and squares
	always_comb begin
		mid_sum = {1'b0, in_data.low} + {1'b0, in_data.high};
		mid_c   = mid_sum[QW:1];
		u_c     = ONE - mid_c;
		uu_prod = u_c * u_c;
		mm_prod = mid_c * mid_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= in_data.t;
			low_s1  <= in_data.low;
			high_s1 <= in_data.high;
			mid_s1  <= mid_c;
			u_s1    <= u_c;
			uu_s1   <= uu_prod[FRAC_BITS +: QW];
			mm_s1   <= mm_prod[FRAC_BITS +: QW];
		end
	end

	// Bernstein terms
	always_comb begin
		tri_uu  = (QW+2)'({uu_s1, 1'b0}) + (QW+2)'(uu_s1);
		tri_u   = (QW+2)'({u_s1, 1'b0}) + (QW+2)'(u_s1);
		b1_prod = tri_uu * mid_s1;
		b2_prod = tri_u * mm_s1;
		b3_prod = mm_s1 * mid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= t_s1;
			low_s2  <= low_s1;
			high_s2 <= high_s1;
			mid_s2  <= mid_s1;
			b1_s2   <= b1_prod[FRAC_BITS +: BW];
			b2_s2   <= b2_prod[FRAC_BITS +: BW];
			b3_s2   <= b3_prod[FRAC_BITS +: QW];
		end
	end

	// x compare and interval update
	always_comb begin
		x1_prod = b1_s2 * px1;
		x2_prod = b2_s2 * px2;
		x_c     = XW'(x1_prod[BW+QW-1:FRAC_BITS]) + XW'(x2_prod[BW+QW-1:FRAC_BITS])
			+ XW'(b3_s2);
		below   = x_c < XW'(t_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.t    <= t_s2;
			out_data.low  <= below ? mid_s2 : low_s2;
			out_data.high <= below ? high_s2 : mid_s2;
			out_data.b1   <= b1_s2;
			out_data.b2   <= b2_s2;
			out_data.b3   <= b3_s2;
		end
	end

endmodule
`default_nettype wire

// ===== design/bcz_yeval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// y evaluation
// Weights the final Bernstein terms by the control point y values, sums and
// saturates the eased value over two stages.
// ----------------------------------------------------------------------------
module bcz_yeval (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire bcz_pkg::bcz_step_t in_data,
	input  wire logic signed [bcz_pkg::CY_W-1:0] ctrl1_y,
	input  wire logic signed [bcz_pkg::CY_W-1:0] ctrl2_y,
	output logic                    out_valid,
	output logic [bcz_pkg::EASED_W-1:0] out_eased
);
	import bcz_pkg::*;

	logic signed [BW+CY_W:0] p1_prod, p2_prod;

	logic                    valid_s1;
	logic signed [PSW-1:0]   p1_s1, p2_s1;
	logic [QW-1:0]           b3_s1;

	logic signed [SUM_W-1:0] y_sum;
	logic [EASED_W-1:0]      y_sat;

	always_comb begin
		p1_prod = $signed({1'b0, in_data.b1}) * ctrl1_y;
		p2_prod = $signed({1'b0, in_data.b2}) * ctrl2_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= p1_prod[BW+CY_W:FRAC_BITS];
			p2_s1 <= p2_prod[BW+CY_W:FRAC_BITS];
			b3_s1 <= in_data.b3;
		end
	end

	// sum and saturate
	always_comb begin
		y_sum = SUM_W'(p1_s1) + SUM_W'(p2_s1) + $signed(SUM_W'(b3_s1));
		if (y_sum < EASED_MIN) begin
			y_sat = EASED_MIN[EASED_W-1:0];
		end else if (y_sum > EASED_MAX) begin
			y_sat = EASED_MAX[EASED_W-1:0];
		end else begin
			y_sat = y_sum[EASED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_eased <= y_sat;
		end
	end

endmodule
`default_nettype wire

// ===== tb/cubic_bezier_easing_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier easing testbench
// Streams progress values through the easing pipeline under several control
// point settings, with bursty input and a stalling output, and compares each
// eased value against a bit-true bisection model kept inside the bench or a table value.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_top_tb;
	import bcz_pkg::*;

	localparam int STEPS       = BISECT_STEPS_DEF;
	localparam int LATENCY     = 3 * STEPS + 4;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_ITEMS = 210;
	localparam int NUM_PHASES  = 6;
	localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;

	typedef logic signed [PROG_W-1:0]  progress_t;
	typedef logic signed [EASED_W-1:0] eased_t;

	typedef struct {
		progress_t prog;
		bit        typed;
		eased_t    eased;
	} progress_row_t;

	typedef struct {
		logic [DATA_W-1:0] c1x;
		logic [DATA_W-1:0] c1y;
		logic [DATA_W-1:0] c2x;
		logic [DATA_W-1:0] c2y;
	} ctrl_set_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              progress_valid = 1'b0;
	logic              progress_stall;
	progress_t         progress       = '0;
	logic              eased_valid;
	logic              eased_stall    = 1'b0;
	eased_t            eased;
	logic              cfg_valid      = 1'b0;
	logic              cfg_ready;
	cfg_reg_t          cfg_index      = CFG_CTRL1_X;
	logic [DATA_W-1:0] cfg_data       = '0;

	longint unsigned curve_c1x = CTRL1_X_RST;
	longint unsigned curve_c2x = CTRL2_X_RST;
	longint          curve_c1y = CTRL1_Y_RST;
	longint          curve_c2y = CTRL2_Y_RST;

	eased_t eased_expect_q[$];
	eased_t eased_want;
	int     mismatches   = 0;
	int     transfers_in = 0;
	int     results_seen = 0;
	int     phases_run   = 0;
	int     burst_left   = 0;
	int     idle_cycles  = 0;

	logic [1:0] stall_mode = 2'd0;
	logic [7:0] stall_cyc  = '0;

	progress_row_t directed_rows [0:19] = '{
		'{18'sh20000, 1'b1, 19'sh0},
		'{18'sh3FFFF, 1'b1, 19'sh0},
		'{18'sh2AAAA, 1'b1, 19'sh0},
		'{18'sh00000, 1'b1, 19'sh0},
		'{18'sh00001, 1'b0, 19'sh0},
		'{18'sh00002, 1'b0, 19'sh0},
		'{18'sh00064, 1'b0, 19'sh0},
		'{18'sh04000, 1'b0, 19'sh0},
		'{18'sh07FFF, 1'b0, 19'sh0},
		'{18'sh08000, 1'b0, 19'sh0},
		'{18'sh08001, 1'b0, 19'sh0},
		'{18'sh0C000, 1'b0, 19'sh0},
		'{18'sh0FF9C, 1'b0, 19'sh0},
		'{18'sh0FFFF, 1'b0, 19'sh0},
		'{18'sh10000, 1'b0, 19'sh0},
		'{18'sh10001, 1'b0, 19'sh0},
		'{18'sh15555, 1'b0, 19'sh0},
		'{18'sh1FFFF, 1'b0, 19'sh0},
		'{18'sh05555, 1'b0, 19'sh0},
		'{18'sh0AAAA, 1'b0, 19'sh0}
	};

	ctrl_set_t ctrl_extremes [0:3] = '{
		'{18'h00000, 18'h20000, 18'h10000, 18'h1FFFF},
		'{18'h10000, 18'h1FFFF, 18'h00000, 18'h20000},
		'{18'h1FFFF, 18'h3FFFF, 18'h3FFFF, 18'h00001},
		'{18'h2AAAA, 18'h15555, 18'h15555, 18'h2AAAA}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cubic_bezier_easing_top #(
		.BISECT_STEPS(STEPS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.progress_valid(progress_valid),
		.progress_stall(progress_stall),
		.progress(progress),
		.eased_valid(eased_valid),
		.eased_stall(eased_stall),
		.eased(eased),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
		return (a * b) >> FRAC_BITS;
	endfunction

	function automatic void bernstein(input longint unsigned mid, output longint unsigned b1,
			output longint unsigned b2, output longint unsigned b3);
		longint unsigned u, uu, mm;
		u  = ONE_Q - mid;
		uu = qmul(u, u);
		mm = qmul(mid, mid);
		b1 = qmul(3 * uu, mid);
		b2 = qmul(3 * u, mm);
		b3 = qmul(mm, mid);
	endfunction

	function automatic eased_t ease_value(input progress_t prog);
		longint          t, y;
		longint unsigned lo, hi, mid, px1, px2, b1, b2, b3, x;
		int              i;
		t = prog;
		if (t < 0)
			t = 0;
		if (t > longint'(ONE_Q))
			t = longint'(ONE_Q);
		px1 = (curve_c1x > ONE_Q) ? ONE_Q : curve_c1x;
		px2 = (curve_c2x > ONE_Q) ? ONE_Q : curve_c2x;
		lo  = 0;
		hi  = ONE_Q;
		mid = ONE_Q >> 1;
		for (i = 0; i < STEPS; i++) begin
			mid = (lo + hi) >> 1;
			bernstein(mid, b1, b2, b3);
			x = qmul(b1, px1) + qmul(b2, px2) + b3;
			if (longint'(x) < t)
				lo = mid;
			else
				hi = mid;
		end
		bernstein(mid, b1, b2, b3);
		y = ((longint'(b1) * curve_c1y) >>> FRAC_BITS) + ((longint'(b2) * curve_c2y) >>> FRAC_BITS)
			+ longint'(b3);
		if (y < longint'(EASED_MIN))
			y = longint'(EASED_MIN);
		if (y > longint'(EASED_MAX))
			y = longint'(EASED_MAX);
		return eased_t'(y);
	endfunction

	function automatic progress_t rand_progress();
		case ($urandom_range(0, 9))
			0: return progress_t'($urandom);
			1: return progress_t'($urandom_range(0, 15));
			2: return progress_t'(ONE_Q - 16 + $urandom_range(0, 32));
			default: return progress_t'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic ctrl_set_t random_ctrl_set();
		ctrl_set_t s;
		s.c1x = $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 65536)) : DATA_W'($urandom);
		s.c2x = $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 65536)) : DATA_W'($urandom);
		s.c1y = DATA_W'($urandom);
		s.c2y = DATA_W'($urandom);
		return s;
	endfunction

	task automatic send_progress(input progress_t v, input bit typed, input eased_t typed_val);
		if (burst_left == 0) begin
			progress_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
		progress_valid <= 1'b1;
		progress       <= v;
		@(posedge clk);
		while (progress_stall)
			@(posedge clk);
		eased_expect_q.push_back(typed ? typed_val : ease_value(v));
		transfers_in++;
		burst_left--;
	endtask

	task automatic drain_results();
		progress_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (eased_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_ctrl(input cfg_reg_t idx, input logic [DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CTRL1_X: curve_c1x = d[QW-1:0];
			CFG_CTRL1_Y: curve_c1y = longint'($signed(d));
			CFG_CTRL2_X: curve_c2x = d[QW-1:0];
			CFG_CTRL2_Y: curve_c2y = longint'($signed(d));
		endcase
		@(posedge clk);
	endtask

	task automatic apply_ctrl_set(input ctrl_set_t s);
		write_ctrl(CFG_CTRL1_X, s.c1x);
		write_ctrl(CFG_CTRL1_Y, s.c1y);
		write_ctrl(CFG_CTRL2_X, s.c2x);
		write_ctrl(CFG_CTRL2_Y, s.c2y);
		phases_run++;
	endtask

	always @(posedge clk) begin
		stall_cyc <= stall_cyc + 1'b1;
		if (stall_cyc == 8'hFF)
			stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: eased_stall <= 1'b0;
			2'd1: eased_stall <= ($urandom_range(0, 3) == 0);
			2'd2: eased_stall <= stall_cyc[3];
			default: eased_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	always @(posedge clk) begin
		if (eased_valid && !eased_stall) begin
			results_seen++;
			if (eased_expect_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("eased transfer with none expected: got %0d", eased);
			end else begin
				eased_want = eased_expect_q.pop_front();
				if (eased !== eased_want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("eased mismatch: expected %0d, got %0d", eased_want, eased);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((progress_valid && !progress_stall) || (eased_valid && !eased_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results outstanding", IDLE_LIMIT,
				eased_expect_q.size());
			$display("cubic_bezier_easing_top test failed");
			$finish;
		end
	end

	initial begin
		int        n;
		int        p;
		int        pause_at;
		ctrl_set_t cur_set;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_progress(directed_rows[i].prog, directed_rows[i].typed, directed_rows[i].eased);
		drain_results();
		for (p = 0; p < NUM_PHASES; p++) begin
			cur_set = (p < 4) ? ctrl_extremes[p] : random_ctrl_set();
			apply_ctrl_set(cur_set);
			pause_at = $urandom_range(20, PHASE_ITEMS - 20);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n == pause_at)
					drain_results();
				send_progress(rand_progress(), 1'b0, '0);
			end
			drain_results();
		end
		repeat (LATENCY + 6) @(posedge clk);
		$display("run covered %0d progress transfers and %0d eased results", transfers_in,
			results_seen);
		$display("under reset control points plus %0d written settings", phases_run);
		if (mismatches == 0 && eased_expect_q.size() == 0) begin
			$display("cubic_bezier_easing_top test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("cubic_bezier_easing_top test failed");
		end
		$finish;
	end

endmodule
